// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the threshold monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ttm_pkg.sv
// ----------------------------------------------------------------------------
// ttm_pkg
// Types and constants shared by the threshold monitor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttm_pkg;

  localparam int VAL_W     = 16;
  localparam int CMD_W     = 3;
  localparam int CHN_W     = 3;
  localparam int KIND_W    = 3;
  localparam int MASK_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LO   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_HI   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADJ_LO   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADJ_HI   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RECHECK  = 3'd5;

  // Result kinds; each kind also names its bit in the pending mask.
  localparam logic [KIND_W-1:0] KIND_READING = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHANGE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LO_TRIG = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HI_TRIG = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LO_ECHO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HI_ECHO = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RECHECK_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_EN  = 1'd1;

  // Last value forced after a threshold write (-255).
  localparam logic signed [VAL_W-1:0] FORCED_LAST = 16'shFF01;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
    logic advance;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mask_empty;
    logic walk_more;
  } dp_status_t;

endpackage

// File: rtl/ttm_ctrl.sv
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer that steps the datapath through evaluation and result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ttm_pkg::dp_status_t status,
  output ttm_pkg::ctrl_cmd_t  cmd,
  output logic               busy
);
  import ttm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.mask_empty) begin
          cmd.emit = 1'b1;
        end else if (status.walk_more) begin
          cmd.advance = 1'b1;
          state_next  = ST_EVAL;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/ttm_datapath.sv
// ----------------------------------------------------------------------------
// ttm_datapath
// Channel state, threshold evaluation and the one-deep result hold stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttm_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ttm_pkg::ctrl_cmd_t                 cmd,
  output ttm_pkg::dp_status_t                status,
  input  logic                               cfg_write_en,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttm_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic [ttm_pkg::CMD_W-1:0]          in_cmd,
  input  logic [ttm_pkg::CHN_W-1:0]          in_channel,
  input  logic signed [ttm_pkg::VAL_W-1:0]   in_value,
  input  logic                               in_online,
  output logic                               result_valid,
  output logic [ttm_pkg::KIND_W-1:0]         kind,
  output logic [ttm_pkg::CHN_W-1:0]          out_channel,
  output logic signed [ttm_pkg::VAL_W-1:0]   out_value,
  output logic                               online_flag,
  output logic                               last_of_run
);
  import ttm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  logic signed [VAL_W-1:0] last_temp [CHANNELS];
  logic signed [VAL_W-1:0] low_thr   [CHANNELS];
  logic signed [VAL_W-1:0] high_thr  [CHANNELS];

  logic recheck_en;
  logic change_en;

  logic [CMD_W-1:0]        cmd_r;
  logic [CHN_W-1:0]        chn_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    online_r;
  logic [IDX_W-1:0]        walk_idx;

  logic [MASK_W-1:0]       mask;
  logic signed [VAL_W-1:0] rv;
  logic [CHN_W-1:0]        rchn;

  logic                    held_valid;
  logic [KIND_W-1:0]       held_kind;
  logic [CHN_W-1:0]        held_chn;
  logic signed [VAL_W-1:0] held_val;
  logic                    held_online;

  // Evaluation signals.
  logic [EXT_W-1:0]        chn_ext;
  logic [EXT_W-1:0]        walk_ext;
  logic                    chn_ok;
  logic                    recheck_mode;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] cur_last;
  logic signed [VAL_W-1:0] cur_lo;
  logic signed [VAL_W-1:0] cur_hi;
  logic signed [VAL_W:0]   diff;
  logic                    big_change;
  logic [MASK_W-1:0]       mask_next;
  logic signed [VAL_W-1:0] rv_next;
  logic [CHN_W-1:0]        rchn_next;
  logic                    wr_last;
  logic signed [VAL_W-1:0] wr_last_val;
  logic                    wr_lo;
  logic                    wr_hi;
  logic signed [VAL_W-1:0] thr_val;

  logic [KIND_W-1:0]       pick;
  logic                    pick_found;

  assign chn_ext      = EXT_W'(chn_r);
  assign walk_ext     = EXT_W'(walk_idx);
  assign chn_ok       = (chn_ext < EXT_W'(CHANNELS));
  assign recheck_mode = (cmd_r == CMD_RECHECK) && recheck_en;
  assign rd_addr      = recheck_mode ? walk_idx : chn_ext[IDX_W-1:0];
  assign cur_last     = last_temp[rd_addr];
  assign cur_lo       = low_thr[rd_addr];
  assign cur_hi       = high_thr[rd_addr];
  assign diff         = (VAL_W+1)'(cur_last) - (VAL_W+1)'(val_r);
  assign big_change   = (diff > 17'sd1) || (diff < -17'sd1);

  always_comb begin
    mask_next   = '0;
    rv_next     = val_r;
    rchn_next   = chn_r;
    wr_last     = 1'b0;
    wr_last_val = val_r;
    wr_lo       = 1'b0;
    wr_hi       = 1'b0;
    thr_val     = val_r;
    case (cmd_r)
      CMD_SAMPLE: begin
        mask_next[KIND_READING] = 1'b1;
        if (chn_ok) begin
          if (!online_r) begin
            wr_last = 1'b1;
          end else if (big_change) begin
            wr_last                 = 1'b1;
            mask_next[KIND_CHANGE]  = change_en;
            mask_next[KIND_LO_TRIG] = (val_r < cur_lo) && (cur_last >= cur_lo);
            mask_next[KIND_HI_TRIG] = (val_r > cur_hi) && (cur_last <= cur_hi);
          end
        end
      end
      CMD_SET_LO, CMD_SET_HI, CMD_ADJ_LO, CMD_ADJ_HI: begin
        if (cmd_r == CMD_ADJ_LO) begin
          thr_val = cur_lo + val_r;
        end else if (cmd_r == CMD_ADJ_HI) begin
          thr_val = cur_hi + val_r;
        end
        if (chn_ok) begin
          wr_last     = 1'b1;
          wr_last_val = FORCED_LAST;
          if ((cmd_r == CMD_SET_LO) || (cmd_r == CMD_ADJ_LO)) begin
            wr_lo                   = 1'b1;
            mask_next[KIND_LO_ECHO] = 1'b1;
          end else begin
            wr_hi                   = 1'b1;
            mask_next[KIND_HI_ECHO] = 1'b1;
          end
        end
        rv_next = thr_val;
      end
      CMD_RECHECK: begin
        rv_next   = cur_last;
        rchn_next = walk_ext[CHN_W-1:0];
        if (recheck_en) begin
          mask_next[KIND_LO_TRIG] = (cur_last < cur_lo);
          mask_next[KIND_HI_TRIG] = (cur_last > cur_hi);
        end
      end
      default: begin
        mask_next = '0;
      end
    endcase
  end

  // Lowest pending kind goes out first, which matches the required order.
  always_comb begin
    pick       = '0;
    pick_found = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (mask[i] && !pick_found) begin
        pick       = KIND_W'(i);
        pick_found = 1'b1;
      end
    end
  end

  assign status.mask_empty = (mask == '0);
  assign status.walk_more  = recheck_mode && (walk_idx != LAST_IDX);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      recheck_en <= 1'b0;
      change_en  <= 1'b1;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_RECHECK_EN) begin
        recheck_en <= cfg_data[0];
      end else if (cfg_index == REG_CHANGE_EN) begin
        change_en <= cfg_data[0];
      end
    end
  end

  // Channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_temp[i] <= '0;
        low_thr[i]   <= '0;
        high_thr[i]  <= '0;
      end
    end else if (cmd.eval) begin
      if (wr_last) begin
        last_temp[rd_addr] <= wr_last_val;
      end
      if (wr_lo) begin
        low_thr[rd_addr] <= thr_val;
      end
      if (wr_hi) begin
        high_thr[rd_addr] <= thr_val;
      end
    end
  end

  // Request capture and walk position.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_cmd;
      chn_r    <= in_channel;
      val_r    <= in_value;
      online_r <= in_online;
    end
    if (cmd.capture) begin
      walk_idx <= '0;
    end else if (cmd.advance) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
  end

  // Pending results of the current evaluation.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.eval) begin
      mask <= mask_next;
    end else if (cmd.emit) begin
      mask <= mask & ~(MASK_W'(1) << pick);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rv   <= rv_next;
      rchn <= rchn_next;
    end
  end

  // One result is held back so the final one can be marked on flush.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.emit) begin
        held_valid <= 1'b1;
        if (held_valid) begin
          result_valid <= 1'b1;
        end
      end else if (cmd.flush) begin
        held_valid <= 1'b0;
        if (held_valid) begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      held_kind   <= pick;
      held_chn    <= rchn;
      held_val    <= rv;
      held_online <= (pick == KIND_READING) ? online_r : 1'b0;
    end
    if (cmd.emit || cmd.flush) begin
      kind        <= held_kind;
      out_channel <= held_chn;
      out_value   <= held_val;
      online_flag <= held_online;
      last_of_run <= cmd.flush;
    end
  end

endmodule

// File: rtl/temperature_threshold_monitor_unit.sv
// ----------------------------------------------------------------------------
// temperature_threshold_monitor_unit
// Per-channel temperature monitor with deadband and threshold alarms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A request is taken when start is high while busy is low, and busy stays
// high until the block can take the next one. Results come out one per
// strobe on result_valid and are never held off, so the receiver must take
// each one in the cycle it appears. The final result of a request carries
// last_of_run and appears in the first cycle after busy falls; a new request
// may be started in that same cycle. Because the final result is only known
// once evaluation is done, every result leaves one step after it is found.
// For each request the controller evaluates one channel per pass (every
// channel in turn for an enabled recheck) and then sends out the results
// of that pass one per cycle, with no stall between them.
// Configuration registers: index 0 enables the recheck walk, index 1 enables
// change reports; write them only while the block is idle.

module temperature_threshold_monitor_unit #(
  parameter int CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_write_en,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttm_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic [ttm_pkg::CMD_W-1:0]          cmd,
  input  logic [ttm_pkg::CHN_W-1:0]          channel,
  input  logic signed [ttm_pkg::VAL_W-1:0]   value,
  input  logic                               sensor_online,
  output logic                               result_valid,
  output logic [ttm_pkg::KIND_W-1:0]         kind,
  output logic [ttm_pkg::CHN_W-1:0]          out_channel,
  output logic signed [ttm_pkg::VAL_W-1:0]   out_value,
  output logic                               online_flag,
  output logic                               last_of_run
);
  import ttm_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // The controller only sequences; all channel state and arithmetic is in the datapath.
  ttm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (ctrl_cmd),
    .busy   (busy)
  );

  ttm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctrl_cmd),
    .status       (dp_status),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_cmd       (cmd),
    .in_channel   (channel),
    .in_value     (value),
    .in_online    (sensor_online),
    .result_valid (result_valid),
    .kind         (kind),
    .out_channel  (out_channel),
    .out_value    (out_value),
    .online_flag  (online_flag),
    .last_of_run  (last_of_run)
  );

  // An accepted request always keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy)
  // A result that is not the last one is only sent while a request runs.
  `ASSERT_IMPLIES(a_mid_result_busy, clk, rst, result_valid && !last_of_run, busy)
  // The last result of a request is sent just after busy falls.
  `ASSERT_IMPLIES(a_last_after_run, clk, rst, result_valid && last_of_run, !busy && $past(busy))

endmodule
